>>> design/frlx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frlx_pkg - shared types and constants of the framed line receiver
// Event codes, character constants, line state and result structures, and
// the hex digit decoder used by the line tracker.
// ----------------------------------------------------------------------------
package frlx_pkg;

    // Largest number of bytes held in one line
    localparam int MAX_LINE = 128;
    // Fill counter holds 0 .. MAX_LINE
    localparam int FILL_W   = $clog2(MAX_LINE + 1);
    // Capacity register width
    localparam int CAP_W    = 8;
    // Comparison width: room for the fill count plus a small offset, and the capacity
    localparam int CMP_W    = (FILL_W > CAP_W) ? FILL_W + 1 : CAP_W + 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

    // Characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;

    // Shortest line that can be good, and saturation of the after-star count
    localparam int MIN_GOOD_LEN  = 5;
    localparam logic [2:0] AFTER_STAR_MAX = 3'd4;

    typedef enum logic [2:0] {
        EV_IGNORED      = 3'd0,
        EV_FRAME_START  = 3'd1,
        EV_BYTE_STORED  = 3'd2,
        EV_LINE_GOOD    = 3'd3,
        EV_LINE_BAD     = 3'd4,
        EV_LINE_DROPPED = 3'd5
    } event_t;

    // Request held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } stage_req_t;

    // Per-line tracking state
    typedef struct packed {
        logic              in_frame;
        logic [FILL_W-1:0] fill_count;
        logic [7:0]        running_xor;
        logic [FILL_W-1:0] star_index;
        logic              star_seen;
        logic [2:0]        after_star_count;
        logic [7:0]        first_hex_char;
        logic [7:0]        second_hex_char;
        logic              last_byte_was_cr;
    } line_state_t;

    // One result
    typedef struct packed {
        event_t     event_res;
        logic [7:0] data_byte;
        logic [6:0] byte_position;
        logic [6:0] line_length;
        logic [7:0] received_checksum;
        logic [7:0] computed_checksum;
    } result_t;

    // Hex digit decode: bit 4 is the valid flag, bits 3:0 the value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_0 && c <= CH_9)
            r = {1'b1, 4'(c - CH_0)};
        else if (c >= CH_UA && c <= CH_UF)
            r = {1'b1, 4'(c - CH_UA + 8'd10)};
        else if (c >= CH_LA && c <= CH_LF_HEX)
            r = {1'b1, 4'(c - CH_LA + 8'd10)};
        return r;
    endfunction

endpackage

>>> design/frlx_input_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frlx_input_stage - input request register
// Captures one received byte per cycle and holds it while the pipeline
// ahead is stalled.
// ----------------------------------------------------------------------------
module frlx_input_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    input  logic                  take,
    output frlx_pkg::stage_req_t  req
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Register is free when empty or when its request moves on this cycle
    assign in_stall   = valid_reg && !take;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload: loaded on accept only
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign req.valid   = valid_reg;
    assign req.rx_byte = byte_reg;

endmodule

>>> design/frlx_line_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frlx_line_tracker - per-byte line state update and result decode
// Holds the frame state and the capacity register, and works out the result
// of the byte in the input register in a single pass.
// ----------------------------------------------------------------------------
module frlx_line_tracker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [frlx_pkg::CAP_W-1:0]     cfg_write_data,
    input  frlx_pkg::stage_req_t           req,
    input  logic                           take,
    output frlx_pkg::result_t              res
);

    localparam int CMP_W = frlx_pkg::CMP_W;

    frlx_pkg::line_state_t         st_reg;
    frlx_pkg::line_state_t         st_next;
    logic [frlx_pkg::CAP_W-1:0]    cap_reg;

    logic [7:0]       b;
    logic [CMP_W-1:0] len_full;
    logic [CMP_W-1:0] len;
    logic [CMP_W-1:0] star_pos;
    logic             held_full;
    logic             strip;
    logic             drop;
    logic [7:0]       computed;
    logic [4:0]       hi;
    logic [4:0]       lo;
    logic             digits_ok;
    logic [7:0]       received;
    logic             good;
    logic             fire;

    assign b    = req.rx_byte;
    assign fire = req.valid && take;

    // Line close terms
    always_comb
    begin
        len_full  = CMP_W'(st_reg.fill_count);
        star_pos  = CMP_W'(st_reg.star_index);
        held_full = len_full >= CMP_W'(frlx_pkg::MAX_LINE);
        strip     = st_reg.last_byte_was_cr;
        len       = (!held_full && strip) ? len_full - CMP_W'(1) : len_full;
        drop      = held_full || (len >= CMP_W'(cap_reg));
        computed  = (strip && !st_reg.star_seen) ? (st_reg.running_xor ^ frlx_pkg::CH_CR)
                                                 : st_reg.running_xor;
        hi        = frlx_pkg::hex_value(st_reg.first_hex_char);
        lo        = frlx_pkg::hex_value(st_reg.second_hex_char);
        digits_ok = st_reg.star_seen && (st_reg.after_star_count >= 3'd2)
                    && (star_pos + CMP_W'(2) < len) && hi[4] && lo[4];
        received  = digits_ok ? {hi[3:0], lo[3:0]} : 8'd0;
        good      = (len >= CMP_W'(frlx_pkg::MIN_GOOD_LEN)) && st_reg.star_seen
                    && digits_ok && (star_pos + CMP_W'(3) == len)
                    && (received == computed);
    end

    // Next state and result of the current byte
    always_comb
    begin
        st_next = st_reg;
        res     = '0;
        res.event_res = frlx_pkg::EV_IGNORED;
        priority if (b == frlx_pkg::CH_DOLLAR)
        begin
            st_next            = '0;
            st_next.in_frame   = 1'b1;
            st_next.fill_count = frlx_pkg::FILL_W'(1);
            res.event_res      = frlx_pkg::EV_FRAME_START;
            res.data_byte      = b;
        end
        else if (!st_reg.in_frame)
        begin
            res.event_res = frlx_pkg::EV_IGNORED;
        end
        else if (b == frlx_pkg::CH_LF)
        begin
            st_next = '0;
            if (drop)
            begin
                res.event_res = frlx_pkg::EV_LINE_DROPPED;
            end
            else
            begin
                res.event_res         = good ? frlx_pkg::EV_LINE_GOOD : frlx_pkg::EV_LINE_BAD;
                res.line_length       = 7'(len);
                res.received_checksum = received;
                res.computed_checksum = computed;
            end
        end
        else if (held_full)
        begin
            // Overflow: the byte is lost and the frame left
            st_next       = '0;
            res.event_res = frlx_pkg::EV_LINE_DROPPED;
        end
        else
        begin
            if (!st_reg.star_seen)
            begin
                if (b == frlx_pkg::CH_STAR)
                begin
                    st_next.star_seen        = 1'b1;
                    st_next.star_index       = st_reg.fill_count;
                    st_next.after_star_count = 3'd0;
                end
                else
                begin
                    st_next.running_xor = st_reg.running_xor ^ b;
                end
            end
            else
            begin
                if (st_reg.after_star_count == 3'd0)
                    st_next.first_hex_char = b;
                else if (st_reg.after_star_count == 3'd1)
                    st_next.second_hex_char = b;
                if (st_reg.after_star_count < frlx_pkg::AFTER_STAR_MAX)
                    st_next.after_star_count = st_reg.after_star_count + 3'd1;
            end
            st_next.last_byte_was_cr = (b == frlx_pkg::CH_CR);
            st_next.fill_count       = st_reg.fill_count + frlx_pkg::FILL_W'(1);
            res.event_res            = frlx_pkg::EV_BYTE_STORED;
            res.data_byte            = b;
            res.byte_position        = 7'(st_reg.fill_count);
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= frlx_pkg::CAP_RESET;
        end
        else if (cfg_write_en)
        begin
            cap_reg <= cfg_write_data;
        end
    end

endmodule

>>> design/frlx_output_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frlx_output_stage - result register
// Holds one result until the consumer takes it; frees itself in the same
// cycle that its contents are taken.
// ----------------------------------------------------------------------------
module frlx_output_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_req_valid,
    input  frlx_pkg::result_t  res,
    output logic               take,
    output logic               out_valid,
    input  logic               out_stall,
    output frlx_pkg::result_t  out_res
);

    logic              valid_reg;
    frlx_pkg::result_t res_reg;

    // Load when empty or when the held result leaves now
    assign take = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= in_req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_req_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

>>> design/framed_line_receiver_xor_check_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_line_receiver_xor_check_top - framed line receiver with XOR check
// Tracks '$'-framed text lines byte by byte and reports each line's status.
// ----------------------------------------------------------------------------
// Takes one received byte per clock while no stall is applied, and gives
// exactly one result per byte. The byte is caught in the input register,
// and its result goes into the result register once that register is free.
// With no stall applied, the sustained rate is one byte per cycle: the whole
// line state update for a byte is a single pass of logic in the line tracker
// between those two registers. A stall on the result side holds a full result
// register at once, and stalls the input side in the same cycle whenever the
// input register is also occupied, so at most two bytes wait inside the block.
// The capacity register resets to 128 and may only be written while no byte
// is in flight.
module framed_line_receiver_xor_check_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [frlx_pkg::CAP_W-1:0] cfg_write_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 event_res,
    output logic [7:0]                 data_byte,
    output logic [6:0]                 byte_position,
    output logic [6:0]                 line_length,
    output logic [7:0]                 received_checksum,
    output logic [7:0]                 computed_checksum
);

    frlx_pkg::stage_req_t req;
    frlx_pkg::result_t    res;
    frlx_pkg::result_t    out_res;
    logic                 take;

    frlx_input_stage u_input
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .take     (take),
        .req      (req)
    );

    frlx_line_tracker u_tracker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req            (req),
        .take           (take),
        .res            (res)
    );

    frlx_output_stage u_output
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_req_valid (req.valid),
        .res          (res),
        .take         (take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_res      (out_res)
    );

    // Result fields to ports
    assign event_res         = 3'(out_res.event_res);
    assign data_byte         = out_res.data_byte;
    assign byte_position     = out_res.byte_position;
    assign line_length       = out_res.line_length;
    assign received_checksum = out_res.received_checksum;
    assign computed_checksum = out_res.computed_checksum;

endmodule

>>> design/frlx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frlx_checker - port-level checks for the framed line receiver
// Watches the top level's ports and flags result contents that cannot occur.
// ----------------------------------------------------------------------------
module frlx_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [frlx_pkg::CAP_W-1:0] cfg_write_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [7:0]                 rx_byte,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [2:0]                 event_res,
    input  logic [7:0]                 data_byte,
    input  logic [6:0]                 byte_position,
    input  logic [6:0]                 line_length,
    input  logic [7:0]                 received_checksum,
    input  logic [7:0]                 computed_checksum
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // Frame start always carries the dollar at position zero
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == 3'(frlx_pkg::EV_FRAME_START))
        |-> (data_byte == frlx_pkg::CH_DOLLAR) && (byte_position == 7'd0))
        else $error("frame start without dollar at position zero");

    // A good line has matching checksums and minimum length
    a_good_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == 3'(frlx_pkg::EV_LINE_GOOD))
        |-> (received_checksum == computed_checksum)
            && (line_length >= 7'(frlx_pkg::MIN_GOOD_LEN)))
        else $error("good line with mismatched checksum or short length");

    // A dropped line reports nothing else
    a_dropped_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == 3'(frlx_pkg::EV_LINE_DROPPED))
        |-> (data_byte == 8'd0) && (byte_position == 7'd0) && (line_length == 7'd0)
            && (received_checksum == 8'd0) && (computed_checksum == 8'd0))
        else $error("dropped line with non-zero fields");

endmodule

bind framed_line_receiver_xor_check_top frlx_checker u_frlx_checker (.*);

>>> bench/framed_line_receiver_xor_check_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_line_receiver_xor_check_top_tb - line receiver checksum bench
// Feeds '$'-framed sentences, noise and broken lines byte by byte through the
// receiver under several line capacity settings. A line tracker in the bench
// predicts the result of every byte, and each result leaving the block is
// compared field by field, in order, with the oldest prediction. Both sides
// idle at random, and the output side holds off for long stretches twice.
// ----------------------------------------------------------------------------
module framed_line_receiver_xor_check_top_tb;

    import frlx_pkg::*;

    localparam int N_PHASES     = 6;
    localparam int PHASE_BYTES  = 255;
    localparam int LONG_HOLD    = 300;
    // capacity per phase; the first phase runs on the reset value
    localparam int CAP_STEPS [N_PHASES] = '{128, 20, 1, 9, 128, 64};
    // opening sentences: noise, restart, a lower case digit, short line
    localparam logic [7:0] OPENING [22] = '{
        8'h00, 8'hFF, CH_LF,
        CH_DOLLAR, CH_DOLLAR, 8'h41, CH_STAR, 8'h34, 8'h31, CH_CR, CH_LF,
        CH_DOLLAR, 8'h6A, CH_STAR, 8'h36, 8'h61, CH_LF,
        CH_DOLLAR, CH_STAR, 8'h30, 8'h30, CH_LF
    };

    typedef enum int {
        SEN_GOOD,
        SEN_BAD_SUM,
        SEN_NO_STAR,
        SEN_BAD_DIGIT,
        SEN_ONE_DIGIT,
        SEN_TRAILING,
        SEN_OPEN_ENDED
    } sentence_kind_t;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_write_en   = 1'b0;
    logic [CAP_W-1:0]     cfg_write_data = '0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte        = 8'h00;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic [2:0]           event_res;
    logic [7:0]           data_byte;
    logic [6:0]           byte_position;
    logic [6:0]           line_length;
    logic [7:0]           received_checksum;
    logic [7:0]           computed_checksum;

    // byte plan, predicted line events, counters
    logic [7:0] rx_plan [$];
    result_t    line_events [$];
    int         planned_bytes = 0;
    int         bytes_taken   = 0;
    int         mismatches    = 0;
    int         events_seen [6] = '{default: 0};
    bit         req_taken     = 1'b0;
    bit         steady_flow   = 1'b0;
    int         hold_requests = 0;
    int         holds_served  = 0;
    int         hold_left     = 0;
    int         stall_left    = 0;
    int         feed_idle     = 0;

    // tracker copy of the line state
    int         cap_limit     = int'(CAP_RESET);
    bit         ln_open       = 1'b0;
    int         ln_fill       = 0;
    logic [7:0] ln_xor        = 8'h00;
    int         ln_star_at    = 0;
    bit         ln_star_seen  = 1'b0;
    int         ln_after_star = 0;
    logic [7:0] ln_hex_hi     = 8'h00;
    logic [7:0] ln_hex_lo     = 8'h00;
    bit         ln_prev_cr    = 1'b0;

    framed_line_receiver_xor_check_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .event_res         (event_res),
        .data_byte         (data_byte),
        .byte_position     (byte_position),
        .line_length       (line_length),
        .received_checksum (received_checksum),
        .computed_checksum (computed_checksum)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line tracker
    // ------------------------------------------------------------------
    function automatic void reset_line();
        ln_fill       = 0;
        ln_xor        = 8'h00;
        ln_star_at    = 0;
        ln_star_seen  = 1'b0;
        ln_after_star = 0;
        ln_hex_hi     = 8'h00;
        ln_hex_lo     = 8'h00;
        ln_prev_cr    = 1'b0;
    endfunction

    // -1 when not a hex digit
    function automatic int hex_digit_value(input logic [7:0] c);
        if (c inside {[CH_0:CH_9]})
            return int'(c - CH_0);
        if (c inside {[CH_UA:CH_UF]})
            return int'(c - CH_UA) + 10;
        if (c inside {[CH_LA:CH_LF_HEX]})
            return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    task automatic track_byte(input logic [7:0] b, output result_t r);
        int         len;
        bit         full;
        bit         strip;
        int         hi;
        int         lo;
        bit         digits_ok;
        logic [7:0] calc;
        logic [7:0] rcvd;
        r = '0;
        if (b == CH_DOLLAR)
        begin
            reset_line();
            ln_open     = 1'b1;
            ln_fill     = 1;
            r.event_res = EV_FRAME_START;
            r.data_byte = b;
        end
        else if (!ln_open)
        begin
            r.event_res = EV_IGNORED;
        end
        else if (b == CH_LF)
        begin
            // close the line, strip one trailing CR
            len     = ln_fill;
            full    = (ln_fill >= MAX_LINE);
            strip   = (len > 0) && ln_prev_cr;
            ln_open = 1'b0;
            if (!full && strip)
                len--;
            if (full || len >= cap_limit)
            begin
                r.event_res = EV_LINE_DROPPED;
            end
            else
            begin
                calc = ln_xor;
                if (strip && !ln_star_seen)
                    calc ^= CH_CR;
                hi        = hex_digit_value(ln_hex_hi);
                lo        = hex_digit_value(ln_hex_lo);
                rcvd      = 8'h00;
                digits_ok = 1'b0;
                if (ln_star_seen && ln_after_star >= 2 && ln_star_at + 2 < len &&
                    hi >= 0 && lo >= 0)
                begin
                    rcvd      = 8'(hi * 16 + lo);
                    digits_ok = 1'b1;
                end
                r.event_res = (len >= MIN_GOOD_LEN && ln_star_seen && digits_ok &&
                               ln_star_at + 3 == len && rcvd == calc) ?
                              EV_LINE_GOOD : EV_LINE_BAD;
                r.line_length       = len[6:0];
                r.received_checksum = rcvd;
                r.computed_checksum = calc;
            end
            reset_line();
        end
        else if (ln_fill >= MAX_LINE)
        begin
            // overflow: byte lost, frame left
            ln_open = 1'b0;
            reset_line();
            r.event_res = EV_LINE_DROPPED;
        end
        else
        begin
            if (!ln_star_seen)
            begin
                if (b == CH_STAR)
                begin
                    ln_star_seen  = 1'b1;
                    ln_star_at    = ln_fill;
                    ln_after_star = 0;
                end
                else
                begin
                    ln_xor ^= b;
                end
            end
            else
            begin
                if (ln_after_star == 0)
                    ln_hex_hi = b;
                else if (ln_after_star == 1)
                    ln_hex_lo = b;
                if (ln_after_star < 4)
                    ln_after_star++;
            end
            ln_prev_cr      = (b == CH_CR);
            r.event_res     = EV_BYTE_STORED;
            r.data_byte     = b;
            r.byte_position = ln_fill[6:0];
            ln_fill++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sentence generation
    // ------------------------------------------------------------------
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // payload byte that neither frames, closes nor marks the checksum
    function automatic logic [7:0] body_char();
        logic [7:0] c;
        c = CH_DOLLAR;
        while (c inside {CH_DOLLAR, CH_STAR, CH_LF})
            c = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(8'h20, 8'h7E))
                                           : 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return CH_0 + 8'(n);
        return (lower ? CH_LA : CH_UA) + 8'(n) - 8'd10;
    endfunction

    task automatic queue_sentence(input int body_len, input sentence_kind_t kind);
        logic [7:0] sum;
        logic [7:0] shown;
        logic [7:0] c;
        int         k;
        int         start;
        int         t;
        bit         lower;
        start = rx_plan.size();
        lower = 1'($urandom_range(0, 1));
        sum   = 8'h00;
        rx_plan.push_back(CH_DOLLAR);
        for (k = 0; k < body_len; k++)
        begin
            c = body_char();
            sum ^= c;
            rx_plan.push_back(c);
        end
        shown = (kind == SEN_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
        if (kind != SEN_NO_STAR)
        begin
            rx_plan.push_back(CH_STAR);
            rx_plan.push_back(nibble_char(shown[7:4], lower));
        end
        if (kind inside {SEN_GOOD, SEN_BAD_SUM, SEN_TRAILING, SEN_OPEN_ENDED})
        begin
            rx_plan.push_back(nibble_char(shown[3:0], lower));
        end
        else if (kind == SEN_BAD_DIGIT)
        begin
            c = body_char();
            while (hex_digit_value(c) >= 0)
                c = body_char();
            rx_plan.push_back(c);
        end
        if (kind == SEN_TRAILING)
        begin
            for (k = $urandom_range(1, 3); k > 0; k--)
                rx_plan.push_back(body_char());
        end
        // terminator: CR LF, bare LF, or a doubled CR
        if (kind != SEN_OPEN_ENDED)
        begin
            t = $urandom_range(0, 9);
            if (t < 6 || t == 9)
                rx_plan.push_back(CH_CR);
            if (t == 9)
                rx_plan.push_back(CH_CR);
            rx_plan.push_back(CH_LF);
        end
        planned_bytes += rx_plan.size() - start;
    endtask

    // wait until nothing is queued or in flight
    task automatic settle();
        while (rx_plan.size() != 0 || in_valid || line_events.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Request side driver: changes on the falling edge, holds when stalled
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : byte_feed
        if (rst_n && (!in_valid || req_taken))
        begin
            if (feed_idle > 0)
            begin
                in_valid <= 1'b0;
                feed_idle--;
            end
            else if (rx_plan.size() != 0)
            begin
                rx_byte   <= rx_plan.pop_front();
                in_valid  <= 1'b1;
                feed_idle = steady_flow ? 0 : idle_span();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure, with long hold-offs on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : result_backpressure
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left = steady_flow ? 0 : idle_span();
        end
    end

    // ------------------------------------------------------------------
    // Rising edge: check results leaving, then predict requests taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_and_predict
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (line_events.size() == 0)
                begin
                    $error("result with none pending: event_res %0d", event_res);
                    mismatches++;
                end
                else
                begin
                    want = line_events.pop_front();
                    check_field("event_res", int'(want.event_res), event_res);
                    check_field("data_byte", want.data_byte, data_byte);
                    check_field("byte_position", want.byte_position, byte_position);
                    check_field("line_length", want.line_length, line_length);
                    check_field("received_checksum", want.received_checksum,
                                received_checksum);
                    check_field("computed_checksum", want.computed_checksum,
                                computed_checksum);
                    events_seen[int'(want.event_res)]++;
                end
            end
            if (in_valid && !in_stall)
            begin
                track_byte(rx_byte, pred);
                line_events.push_back(pred);
                bytes_taken++;
            end
            req_taken <= in_valid && !in_stall;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, opening sentences, then random phases per capacity
    // ------------------------------------------------------------------
    initial
    begin
        int             p;
        int             k;
        int             r;
        int             budget;
        int             body_len;
        sentence_kind_t kind;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (OPENING[i])
            rx_plan.push_back(OPENING[i]);

        for (p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                cfg_write_en   <= 1'b1;
                cfg_write_data <= CAP_W'(CAP_STEPS[p]);
                cap_limit      = CAP_STEPS[p];
                @(negedge clk);
                cfg_write_en   <= 1'b0;
            end
            steady_flow = (p == 1);
            // output hold-off while the sender keeps offering
            if (p == 1 || p == 4)
                hold_requests++;
            budget = planned_bytes + PHASE_BYTES;
            while (planned_bytes < budget)
            begin
                // stray bytes, ignored unless a line is left open
                if ($urandom_range(0, 3) == 0)
                begin
                    for (k = $urandom_range(1, 4); k > 0; k--)
                    begin
                        r = $urandom_range(0, 255);
                        rx_plan.push_back((8'(r) == CH_DOLLAR) ? CH_LF : 8'(r));
                    end
                end
                r = $urandom_range(0, 99);
                if (r < 5)
                    body_len = $urandom_range(124, 132);
                else if (r < 25)
                    body_len = $urandom_range(8, 40);
                else
                    body_len = $urandom_range(0, 12);
                r = $urandom_range(0, 99);
                if (r < 50)
                    kind = SEN_GOOD;
                else if (r < 60)
                    kind = SEN_BAD_SUM;
                else if (r < 68)
                    kind = SEN_NO_STAR;
                else if (r < 76)
                    kind = SEN_BAD_DIGIT;
                else if (r < 84)
                    kind = SEN_ONE_DIGIT;
                else if (r < 92)
                    kind = SEN_TRAILING;
                else
                    kind = SEN_OPEN_ENDED;
                // long lines without a star also probe the full-buffer newline
                if (body_len > 120 && $urandom_range(0, 1) == 1)
                    kind = SEN_NO_STAR;
                queue_sentence(body_len, kind);
            end
        end

        settle();
        repeat (10) @(negedge clk);

        $display("Covered %0d bytes over %0d capacity settings from 1 to 128, %s",
                 bytes_taken, N_PHASES, "with random idling and long output hold-offs.");
        $display("Events: %0d ignored, %0d starts, %0d stored, %0d good, %0d bad, %0d dropped",
                 events_seen[0], events_seen[1], events_seen[2],
                 events_seen[3], events_seen[4], events_seen[5]);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> framed_line_receiver_xor_check_top.f
design/frlx_pkg.sv
design/frlx_input_stage.sv
design/frlx_line_tracker.sv
design/frlx_output_stage.sv
design/framed_line_receiver_xor_check_top.sv
design/frlx_checker.sv
bench/framed_line_receiver_xor_check_top_tb.sv
